// ===== hdl/ccc_pkg.sv =====
// Shared types, constants and helper functions for the cooking countdown controller.
// No dependencies; compiled first.
package ccc_pkg;

   // Field widths
   localparam int OPCODE_W  = 3;
   localparam int KEY_W     = 8;
   localparam int MODE_W    = 3;
   localparam int SECS_W    = 13;
   localparam int PER_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   // Limits and timing constants
   localparam logic [SECS_W-1:0] MAX_SECONDS      = 13'd6039;
   localparam logic [PER_W-1:0]  MAX_PER_UNIT     = 10'd600;
   localparam logic [SECS_W-1:0] SECS_PER_TEN     = 13'd10;
   localparam logic [SECS_W-1:0] SECS_PER_MIN     = 13'd60;
   localparam logic [SECS_W-1:0] SECS_PER_TEN_MIN = 13'd600;
   // floor(s * RECIP_60 / 2^20) == s / 60 for every s up to MAX_SECONDS
   localparam logic [14:0]       RECIP_60         = 15'd17477;
   localparam int                RECIP_SHIFT      = 20;

   // Register reset values
   localparam logic [SECS_W-1:0] POPCORN_RESET = 13'd60;
   localparam logic [PER_W-1:0]  BEEF_RESET    = 10'd30;
   localparam logic [PER_W-1:0]  CHICKEN_RESET = 10'd12;

   localparam int FLASH_STEPS_DEFAULT = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POPCORN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEF    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHICKEN = 2'd2;

   // Event opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_KEY        = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_PAUSE      = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_START      = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DOOR_OPEN  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DOOR_CLOSE = 3'd5;

   // Keypad codes (ASCII)
   localparam logic [KEY_W-1:0] KEY_POPCORN = 8'h41;  // 'A'
   localparam logic [KEY_W-1:0] KEY_BEEF    = 8'h42;  // 'B'
   localparam logic [KEY_W-1:0] KEY_CHICKEN = 8'h43;  // 'C'
   localparam logic [KEY_W-1:0] KEY_ENTRY   = 8'h44;  // 'D'
   localparam logic [KEY_W-1:0] KEY_ZERO    = 8'h30;  // '0'
   localparam logic [KEY_W-1:0] KEY_NINE    = 8'h39;  // '9'

   // Reported mode codes
   localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WEIGHT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ENTRY  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COOK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PAUSED = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FLASH  = 3'd5;

   // Controller state, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_WEIGHT = 6'b000010,
      ST_ENTRY  = 6'b000100,
      ST_COOK   = 6'b001000,
      ST_PAUSED = 6'b010000,
      ST_FLASH  = 6'b100000
   } mode_state_type;

   // Four entry digits, index 0 = seconds units .. 3 = minute tens
   typedef logic [3:0][3:0] digit_set_type;

   function automatic logic [MODE_W-1:0] mode_code(input mode_state_type st);
      logic [MODE_W-1:0] code;
      case (st)
         ST_IDLE:   code = MODE_IDLE;
         ST_WEIGHT: code = MODE_WEIGHT;
         ST_ENTRY:  code = MODE_ENTRY;
         ST_COOK:   code = MODE_COOK;
         ST_PAUSED: code = MODE_PAUSED;
         ST_FLASH:  code = MODE_FLASH;
         default:   code = MODE_IDLE;
      endcase
      return code;
   endfunction

   // mm:ss digits to seconds
   function automatic logic [SECS_W-1:0] entry_total(input digit_set_type d);
      return SECS_W'(d[0]) + SECS_W'(d[1]) * SECS_PER_TEN
           + SECS_W'(d[2]) * SECS_PER_MIN + SECS_W'(d[3]) * SECS_PER_TEN_MIN;
   endfunction

   // Divide by ten for values up to 109, by threshold compares
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [3:0] q;
      q = '0;
      for (int i = 1; i <= 10; i++) begin
         if (v >= 7'(10 * i)) q = 4'(i);
      end
      return q;
   endfunction

endpackage

// ===== hdl/ccc_intf.sv =====
// Channel interfaces for the cooking countdown controller: event input,
// result output and register write port. Depends on ccc_pkg.
interface ccc_req_if import ccc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [KEY_W-1:0]    key_code;

   modport source (output valid, output opcode, output key_code, input ready);
   modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

interface ccc_rsp_if import ccc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [SECS_W-1:0] remaining_seconds;
   logic [3:0]        minute_tens;
   logic [3:0]        minute_units;
   logic [2:0]        second_tens;
   logic [3:0]        second_units;
   logic              display_blank;
   logic              cooking_done;

   modport source (output valid, output mode, output remaining_seconds,
                   output minute_tens, output minute_units, output second_tens,
                   output second_units, output display_blank, output cooking_done,
                   input ready);
   modport sink   (input valid, input mode, input remaining_seconds,
                   input minute_tens, input minute_units, input second_tens,
                   input second_units, input display_blank, input cooking_done,
                   output ready);
endinterface

interface ccc_csr_if import ccc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] wr_index;
   logic [CSR_DAT_W-1:0] wr_data;

   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== hdl/cooking_countdown_controller_core.sv =====
// Cooking countdown controller top level: event decode, timer state and display digits.
// Depends on ccc_pkg and the channel interfaces in ccc_intf.sv.
//
// Every accepted event transaction yields exactly one result transaction, in order.
// The block takes one event per clock cycle while results are taken. A result is
// presented on the result port once its event has gone from the input register
// through the state update into the snapshot register, then through the display digit
// split into the result register. The pipeline stalls only when the result register
// is full and not taken. The state update is done as an event leaves the input
// register, so back-to-back events chain through it without gaps. Register writes are
// always taken (csr ready tied high); popcorn and per-unit times (low 10 data bits)
// saturate to 6039 s and 600 s on write. No clearing pass is needed after reset.
module cooking_countdown_controller_core import ccc_pkg::*; #(
   parameter int FLASH_STEPS = FLASH_STEPS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   ccc_req_if.sink     req_if,
   ccc_rsp_if.source   rsp_if,
   ccc_csr_if.sink     csr_if
);

   localparam int FLASH_W = $clog2(FLASH_STEPS + 1);

   // Pipeline control
   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_en, b_en, c_en, a_move, b_move;

   assign c_en   = !c_valid_ff || rsp_if.ready;
   assign b_en   = !b_valid_ff || c_en;
   assign a_en   = !a_valid_ff || b_en;
   assign a_move = a_valid_ff && b_en;
   assign b_move = b_valid_ff && c_en;

   assign req_if.ready = a_en;
   assign csr_if.ready = 1'b1;

   // Configuration registers, saturated on write
   logic [SECS_W-1:0] popcorn_ff;
   logic [PER_W-1:0]  beef_ff, chicken_ff;
   logic [PER_W-1:0]  csr_per;

   assign csr_per = (csr_if.wr_data[PER_W-1:0] > MAX_PER_UNIT) ? MAX_PER_UNIT
                                                              : csr_if.wr_data[PER_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         popcorn_ff <= POPCORN_RESET;
         beef_ff    <= BEEF_RESET;
         chicken_ff <= CHICKEN_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.wr_index)
            CSR_POPCORN: popcorn_ff <= (csr_if.wr_data > MAX_SECONDS) ? MAX_SECONDS
                                                                     : csr_if.wr_data;
            CSR_BEEF:    beef_ff    <= csr_per;
            CSR_CHICKEN: chicken_ff <= csr_per;
            default:     ;
         endcase
      end
   end

   // Stage A: input register
   logic [OPCODE_W-1:0] a_op_ff;
   logic [KEY_W-1:0]    a_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en && req_if.valid) begin
         a_op_ff  <= req_if.opcode;
         a_key_ff <= req_if.key_code;
      end
   end

   // Controller state
   mode_state_type      mode_ff, mode_in;
   logic                kind_ff, kind_in;
   logic [SECS_W-1:0]   secs_ff, secs_in;
   digit_set_type       digits_ff, digits_in;
   logic                pause_ff, pause_in;
   logic [FLASH_W-1:0]  flash_ff, flash_in;
   logic                door_ff, door_in;
   logic                blank_in, done_in;

   logic                is_digit;
   logic [3:0]          digit_val;
   digit_set_type       digits_shift;
   logic [PER_W-1:0]    per_unit;
   logic [SECS_W-1:0]   weight_secs;
   logic [SECS_W-1:0]   secs_dec;
   logic [FLASH_W-1:0]  flash_inc;
   logic                start_req, idle_req;
   logic [SECS_W-1:0]   start_secs;

   assign is_digit     = (a_key_ff >= KEY_ZERO) && (a_key_ff <= KEY_NINE);
   assign digit_val    = is_digit ? a_key_ff[3:0] : 4'd0;
   assign digits_shift = {digits_ff[2], digits_ff[1], digits_ff[0], digit_val};
   assign per_unit     = kind_ff ? chicken_ff : beef_ff;
   // at most 9 * 600, always below the display limit
   assign weight_secs  = SECS_W'(digit_val) * SECS_W'(per_unit);
   assign secs_dec     = (secs_ff != '0) ? secs_ff - 1'b1 : secs_ff;
   assign flash_inc    = flash_ff + 1'b1;

   // Event decode and next state
   always_comb begin
      mode_in    = mode_ff;
      kind_in    = kind_ff;
      secs_in    = secs_ff;
      digits_in  = digits_ff;
      pause_in   = pause_ff;
      flash_in   = flash_ff;
      door_in    = door_ff;
      blank_in   = 1'b0;
      done_in    = 1'b0;
      start_req  = 1'b0;
      idle_req   = 1'b0;
      start_secs = '0;

      if (a_move) begin
         case (a_op_ff)
            OP_TICK: begin
               if (!door_ff) begin
                  if (mode_ff == ST_COOK) begin
                     secs_in = secs_dec;
                     if (secs_dec == '0) begin
                        mode_in  = ST_FLASH;
                        flash_in = '0;
                     end
                  end else if (mode_ff == ST_FLASH) begin
                     blank_in = flash_inc[0];
                     flash_in = flash_inc;
                     if (flash_inc >= FLASH_W'(FLASH_STEPS)) begin
                        idle_req = 1'b1;
                        done_in  = 1'b1;
                     end
                  end
               end
            end
            OP_KEY: begin
               if (mode_ff == ST_IDLE) begin
                  if (a_key_ff == KEY_POPCORN) begin
                     start_req  = 1'b1;
                     start_secs = popcorn_ff;
                  end else if (a_key_ff == KEY_BEEF || a_key_ff == KEY_CHICKEN) begin
                     kind_in = (a_key_ff == KEY_CHICKEN);
                     secs_in = '0;
                     mode_in = ST_WEIGHT;
                  end else if (a_key_ff == KEY_ENTRY) begin
                     digits_in = '0;
                     secs_in   = '0;
                     pause_in  = 1'b0;
                     mode_in   = ST_ENTRY;
                  end
               end else if (mode_ff == ST_WEIGHT) begin
                  if (is_digit) begin
                     start_req  = 1'b1;
                     start_secs = weight_secs;
                  end
               end else if (mode_ff == ST_ENTRY) begin
                  if (is_digit && !pause_ff) begin
                     digits_in = digits_shift;
                     secs_in   = entry_total(digits_shift);
                  end
               end
            end
            OP_PAUSE: begin
               if (mode_ff == ST_COOK) begin
                  pause_in = 1'b1;
                  mode_in  = ST_PAUSED;
               end else if (mode_ff == ST_PAUSED) begin
                  idle_req = 1'b1;
               end else if (mode_ff == ST_ENTRY) begin
                  if (!pause_ff) pause_in = 1'b1;
                  else           idle_req = 1'b1;
               end
            end
            OP_START: begin
               if (mode_ff == ST_PAUSED) begin
                  pause_in = 1'b0;
                  mode_in  = ST_COOK;
               end else if (mode_ff == ST_ENTRY) begin
                  start_req  = 1'b1;
                  start_secs = entry_total(digits_ff);
               end
            end
            OP_DOOR_OPEN:  door_in = 1'b1;
            OP_DOOR_CLOSE: door_in = 1'b0;
            default: ;
         endcase

         // Start cooking; a zero time drops straight back to idle
         if (start_req) begin
            pause_in = 1'b0;
            if (start_secs == '0) begin
               idle_req = 1'b1;
            end else begin
               secs_in = start_secs;
               mode_in = ST_COOK;
            end
         end

         if (idle_req) begin
            mode_in  = ST_IDLE;
            secs_in  = '0;
            pause_in = 1'b0;
            flash_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ST_IDLE;
         kind_ff   <= 1'b0;
         secs_ff   <= '0;
         digits_ff <= '0;
         pause_ff  <= 1'b0;
         flash_ff  <= '0;
         door_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         kind_ff   <= kind_in;
         secs_ff   <= secs_in;
         digits_ff <= digits_in;
         pause_ff  <= pause_in;
         flash_ff  <= flash_in;
         door_ff   <= door_in;
      end
   end

   // Stage B: state snapshot for the result
   logic [MODE_W-1:0] b_mode_ff;
   logic [SECS_W-1:0] b_secs_ff;
   logic              b_blank_ff, b_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_mode_ff  <= mode_code(mode_in);
         b_secs_ff  <= secs_in;
         b_blank_ff <= blank_in;
         b_done_ff  <= done_in;
      end
   end

   // Stage C: mm:ss digit split into the result register
   logic [27:0] min_prod;
   logic [6:0]  minutes;
   logic [5:0]  sec_in_min;
   logic [3:0]  min_tens, min_units, sec_units;
   logic [2:0]  sec_tens;
   logic [3:0]  sec_tens_w;

   assign min_prod   = 28'(b_secs_ff) * 28'(RECIP_60);
   assign minutes    = min_prod[RECIP_SHIFT +: 7];
   assign sec_in_min = 6'(b_secs_ff - ((SECS_W'(minutes) << 6) - (SECS_W'(minutes) << 2)));
   assign min_tens   = div10(minutes);
   assign min_units  = 4'(minutes - ((7'(min_tens) << 3) + (7'(min_tens) << 1)));
   assign sec_tens_w = div10({1'b0, sec_in_min});
   assign sec_tens   = sec_tens_w[2:0];
   assign sec_units  = 4'(sec_in_min - ((6'(sec_tens_w) << 3) + (6'(sec_tens_w) << 1)));

   logic [MODE_W-1:0] rsp_mode_ff;
   logic [SECS_W-1:0] rsp_secs_ff;
   logic [3:0]        rsp_mt_ff, rsp_mu_ff, rsp_su_ff;
   logic [2:0]        rsp_st_ff;
   logic              rsp_blank_ff, rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         rsp_mode_ff  <= b_mode_ff;
         rsp_secs_ff  <= b_secs_ff;
         rsp_mt_ff    <= min_tens;
         rsp_mu_ff    <= min_units;
         rsp_st_ff    <= sec_tens;
         rsp_su_ff    <= sec_units;
         rsp_blank_ff <= b_blank_ff;
         rsp_done_ff  <= b_done_ff;
      end
   end

   assign rsp_if.valid             = c_valid_ff;
   assign rsp_if.mode              = rsp_mode_ff;
   assign rsp_if.remaining_seconds = rsp_secs_ff;
   assign rsp_if.minute_tens       = rsp_mt_ff;
   assign rsp_if.minute_units      = rsp_mu_ff;
   assign rsp_if.second_tens       = rsp_st_ff;
   assign rsp_if.second_units      = rsp_su_ff;
   assign rsp_if.display_blank     = rsp_blank_ff;
   assign rsp_if.cooking_done      = rsp_done_ff;

   // Checks
   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.cooking_done |->
         rsp_if.mode == MODE_IDLE && rsp_if.remaining_seconds == '0)
      else $error("cooking_done reported outside idle");

   // an odd flash length ends on a blank step, reported as idle
   a_blank_in_flash: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.display_blank |->
         rsp_if.mode == MODE_FLASH || rsp_if.cooking_done)
      else $error("blank display outside finish flash");

   a_cook_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ST_COOK |-> secs_ff != '0)
      else $error("cooking with zero seconds left");

   a_pause_mode: assert property (@(posedge clock) disable iff (reset)
      pause_ff |-> mode_ff == ST_PAUSED || mode_ff == ST_ENTRY)
      else $error("pause flag set outside paused or time entry");

   a_digits_match: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |->
         SECS_W'(rsp_if.minute_tens) * SECS_PER_TEN_MIN
         + SECS_W'(rsp_if.minute_units) * SECS_PER_MIN
         + SECS_W'(rsp_if.second_tens) * SECS_PER_TEN
         + SECS_W'(rsp_if.second_units) == rsp_if.remaining_seconds)
      else $error("display digits do not match remaining seconds");

endmodule

// ===== tb/cooking_countdown_controller_core_test.sv =====
// Self-checking testbench for cooking_countdown_controller_core: a directed table,
// then randomised cooking sessions checked against an in-bench timer predictor.
// Depends on ccc_pkg, the channel interfaces in ccc_intf.sv and the core itself.
module cooking_countdown_controller_core_test import ccc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLASH_LEN      = FLASH_STEPS_DEFAULT;
   localparam int DIRECTED_ROWS  = 25;
   localparam int RANDOM_ITEMS   = 900;
   localparam int PHASES         = 6;
   localparam int RX_HOLD_CYCLES = 64;
   localparam int QUIET_LIMIT    = 2000;
   localparam int REPORT_LIMIT   = 10;

   // opcodes the block does not decode, and a key that is no digit
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
   localparam logic [KEY_W-1:0]    KEY_STRAY   = 8'h78;  // 'x'

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SECS_W-1:0] secs;
      logic [3:0]        min_tens;
      logic [3:0]        min_units;
      logic [2:0]        sec_tens;
      logic [3:0]        sec_units;
      logic              blank;
      logic              done;
   } readout_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [KEY_W-1:0]    key;
      logic                pinned;  // expected readout typed in below
      logic [MODE_W-1:0]   mode;
      logic [SECS_W-1:0]   secs;
      logic                blank;
      logic                done;
   } event_row_type;

   logic clock;
   logic reset;

   ccc_req_if req_if ();
   ccc_rsp_if rsp_if ();
   ccc_csr_if csr_if ();

   cooking_countdown_controller_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Directed events: idle, unknown opcode, popcorn with pause/resume/cancel,
   // weight entry with stray key and zero time, frozen mm:ss entry, door hold,
   // and a full finish flash.
   event_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_TICK,       8'h00,          1'b1, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_SPARE_HI,   8'hFF,          1'b1, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_KEY,        KEY_POPCORN,    1'b1, MODE_COOK,   13'd60, 1'b0, 1'b0},
      '{OP_PAUSE,      8'h00,          1'b1, MODE_PAUSED, 13'd60, 1'b0, 1'b0},
      '{OP_START,      8'h00,          1'b1, MODE_COOK,   13'd60, 1'b0, 1'b0},
      '{OP_PAUSE,      8'h00,          1'b0, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_PAUSE,      8'h00,          1'b1, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_KEY,        KEY_CHICKEN,    1'b1, MODE_WEIGHT, 13'd0,  1'b0, 1'b0},
      '{OP_KEY,        KEY_STRAY,      1'b1, MODE_WEIGHT, 13'd0,  1'b0, 1'b0},
      '{OP_KEY,        KEY_ZERO,       1'b1, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_KEY,        KEY_ENTRY,      1'b1, MODE_ENTRY,  13'd0,  1'b0, 1'b0},
      '{OP_KEY,        KEY_ZERO + 8'd1, 1'b1, MODE_ENTRY, 13'd1,  1'b0, 1'b0},
      '{OP_PAUSE,      8'h00,          1'b0, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_KEY,        KEY_NINE,       1'b1, MODE_ENTRY,  13'd1,  1'b0, 1'b0},
      '{OP_START,      8'h00,          1'b1, MODE_COOK,   13'd1,  1'b0, 1'b0},
      '{OP_DOOR_OPEN,  8'h00,          1'b0, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_COOK,   13'd1,  1'b0, 1'b0},
      '{OP_DOOR_CLOSE, 8'h00,          1'b0, MODE_IDLE,   13'd0,  1'b0, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_FLASH,  13'd0,  1'b0, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_FLASH,  13'd0,  1'b1, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_FLASH,  13'd0,  1'b0, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_FLASH,  13'd0,  1'b1, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_FLASH,  13'd0,  1'b0, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_FLASH,  13'd0,  1'b1, 1'b0},
      '{OP_TICK,       8'h00,          1'b1, MODE_IDLE,   13'd0,  1'b0, 1'b1}
   };

   // Predicted timer state and register copies
   logic [MODE_W-1:0] oven_mode;
   logic              chicken_sel;
   int                timer_secs;
   digit_set_type     typed_digits;
   logic              paused_once;
   int                flash_ticks;
   logic              door_ajar;
   int                popcorn_time;
   int                beef_rate;
   int                chicken_rate;

   readout_type expected_readouts [$];

   // Run statistics
   int events_sent;
   int changed_events;
   int results_checked;
   int cooks_finished;
   int csr_writes;
   int faults;
   int tx_calm_left;
   int rx_calm_left;
   logic rx_hold_pending;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Timer predictor
   // ---------------------------------------------------------------
   function automatic readout_type make_readout(input logic [MODE_W-1:0] m, input int s,
                                                input logic b, input logic d);
      readout_type r;
      r.mode      = m;
      r.secs      = SECS_W'(s);
      r.min_tens  = 4'(s / 600);
      r.min_units = 4'((s / 60) % 10);
      r.sec_tens  = 3'((s % 60) / 10);
      r.sec_units = 4'(s % 10);
      r.blank     = b;
      r.done      = d;
      return r;
   endfunction

   function automatic void init_timer();
      popcorn_time = int'(POPCORN_RESET);
      beef_rate    = int'(BEEF_RESET);
      chicken_rate = int'(CHICKEN_RESET);
      oven_mode    = MODE_IDLE;
      chicken_sel  = 1'b0;
      timer_secs   = 0;
      typed_digits = '0;
      paused_once  = 1'b0;
      flash_ticks  = 0;
      door_ajar    = 1'b0;
   endfunction

   function automatic void return_to_idle();
      oven_mode   = MODE_IDLE;
      timer_secs  = 0;
      paused_once = 1'b0;
      flash_ticks = 0;
   endfunction

   // zero seconds goes straight back to idle, no flash
   function automatic void start_cooking(input int secs);
      paused_once = 1'b0;
      if (secs == 0) begin
         return_to_idle();
      end else begin
         timer_secs = secs;
         oven_mode  = MODE_COOK;
      end
   endfunction

   function automatic int digits_to_secs();
      return int'(typed_digits[0]) + 10 * int'(typed_digits[1])
           + 60 * int'(typed_digits[2]) + 600 * int'(typed_digits[3]);
   endfunction

   function automatic logic [63:0] timer_state_word();
      return {oven_mode, chicken_sel, SECS_W'(timer_secs), typed_digits, paused_once,
              8'(flash_ticks), door_ajar};
   endfunction

   // Applies one event to the predicted state and returns the readout it gives
   function automatic readout_type advance_timer(input logic [OPCODE_W-1:0] op,
                                                 input logic [KEY_W-1:0] key);
      logic       blank;
      logic       done;
      logic       is_digit;
      logic [3:0] digit;
      int         rate;
      int         total;
      blank    = 1'b0;
      done     = 1'b0;
      is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
      digit    = is_digit ? 4'(key - KEY_ZERO) : 4'd0;
      case (op)
         OP_TICK: begin
            // an open door holds the countdown and the flash
            if (!door_ajar) begin
               if (oven_mode == MODE_COOK) begin
                  if (timer_secs > 0) timer_secs--;
                  if (timer_secs == 0) begin
                     oven_mode   = MODE_FLASH;
                     flash_ticks = 0;
                  end
               end else if (oven_mode == MODE_FLASH) begin
                  flash_ticks++;
                  blank = (flash_ticks % 2) == 1;
                  if (flash_ticks >= FLASH_LEN) begin
                     return_to_idle();
                     done = 1'b1;
                  end
               end
            end
         end
         OP_KEY: begin
            case (oven_mode)
               MODE_IDLE: begin
                  if (key == KEY_POPCORN) begin
                     start_cooking(popcorn_time > int'(MAX_SECONDS) ?
                                   int'(MAX_SECONDS) : popcorn_time);
                  end else if (key == KEY_BEEF || key == KEY_CHICKEN) begin
                     chicken_sel = (key == KEY_CHICKEN);
                     timer_secs  = 0;
                     oven_mode   = MODE_WEIGHT;
                  end else if (key == KEY_ENTRY) begin
                     typed_digits = '0;
                     timer_secs   = 0;
                     paused_once  = 1'b0;
                     oven_mode    = MODE_ENTRY;
                  end
               end
               MODE_WEIGHT: begin
                  if (is_digit) begin
                     rate  = chicken_sel ? chicken_rate : beef_rate;
                     if (rate > int'(MAX_PER_UNIT)) rate = int'(MAX_PER_UNIT);
                     total = int'(digit) * rate;
                     if (total > int'(MAX_SECONDS)) total = int'(MAX_SECONDS);
                     start_cooking(total);
                  end
               end
               MODE_ENTRY: begin
                  // digits shift in from the right unless the entry is frozen
                  if (is_digit && !paused_once) begin
                     typed_digits = {typed_digits[2:0], digit};
                     timer_secs   = digits_to_secs();
                  end
               end
               default: ;
            endcase
         end
         OP_PAUSE: begin
            if (oven_mode == MODE_COOK) begin
               paused_once = 1'b1;
               oven_mode   = MODE_PAUSED;
            end else if (oven_mode == MODE_PAUSED) begin
               return_to_idle();
            end else if (oven_mode == MODE_ENTRY) begin
               if (!paused_once) paused_once = 1'b1;
               else return_to_idle();
            end
         end
         OP_START: begin
            if (oven_mode == MODE_PAUSED) begin
               paused_once = 1'b0;
               oven_mode   = MODE_COOK;
            end else if (oven_mode == MODE_ENTRY) begin
               start_cooking(digits_to_secs());
            end
         end
         OP_DOOR_OPEN:  door_ajar = 1'b1;
         OP_DOOR_CLOSE: door_ajar = 1'b0;
         default: ;
      endcase
      return make_readout(oven_mode, timer_secs, blank, done);
   endfunction

   // ---------------------------------------------------------------
   // Event sender
   // ---------------------------------------------------------------
   function automatic logic [KEY_W-1:0] digit_key();
      return KEY_ZERO + KEY_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [KEY_W-1:0] stray_key();
      logic [KEY_W-1:0] k;
      k = KEY_W'($urandom_range(0, 255));
      if (k >= KEY_ZERO && k <= KEY_NINE) k = KEY_STRAY;
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] any_key();
      return KEY_W'($urandom_range(0, 255));
   endfunction

   // One event transaction; the readout is predicted on acceptance
   task automatic send_event(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic pinned, input readout_type pinned_readout);
      int          gap;
      logic [63:0] prior;
      readout_type predicted;
      if (tx_calm_left > 0) begin
         gap = 0;
         tx_calm_left--;
      end else begin
         gap = $urandom_range(0, 7);
         if ($urandom_range(0, 24) == 0) tx_calm_left = $urandom_range(10, 40);
      end
      if (gap != 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.opcode   = op;
      req_if.key_code = key;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      prior     = timer_state_word();
      predicted = advance_timer(op, key);
      expected_readouts.push_back(pinned ? pinned_readout : predicted);
      events_sent++;
      if (timer_state_word() != prior) changed_events++;
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic offer(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key);
      send_event(op, key, 1'b0, '0);
   endtask

   // Walks the timer back to idle from whatever mode it is in
   task automatic leave_to_idle();
      while (oven_mode != MODE_IDLE) begin
         if (oven_mode == MODE_WEIGHT) begin
            offer(OP_KEY, KEY_ZERO);
         end else if (oven_mode == MODE_FLASH) begin
            if (door_ajar) offer(OP_DOOR_CLOSE, any_key());
            else offer(OP_TICK, any_key());
         end else begin
            offer(OP_PAUSE, any_key());
         end
      end
   endtask

   // A cooking session: load a time, then count down with pauses, door events, stray keys and unknown opcodes
   task automatic cook_session();
      int pick;
      int steps;
      int r;
      if (door_ajar) offer(OP_DOOR_CLOSE, any_key());
      leave_to_idle();
      pick = $urandom_range(0, 3);
      case (pick)
         0: offer(OP_KEY, KEY_POPCORN);
         1, 2: begin
            offer(OP_KEY, (pick == 1) ? KEY_BEEF : KEY_CHICKEN);
            if ($urandom_range(0, 2) == 0) offer(OP_KEY, stray_key());
            offer(OP_KEY, digit_key());
         end
         default: begin
            offer(OP_KEY, KEY_ENTRY);
            repeat ($urandom_range(1, 4)) offer(OP_KEY, digit_key());
            if ($urandom_range(0, 3) == 0) begin
               offer(OP_PAUSE, any_key());
               offer(OP_KEY, digit_key());
            end
            if ($urandom_range(0, 4) == 0) offer(OP_PAUSE, any_key());
            else offer(OP_START, any_key());
         end
      endcase
      steps = 0;
      while (oven_mode != MODE_IDLE && steps < 150) begin
         r = $urandom_range(0, 99);
         if (oven_mode == MODE_PAUSED) begin
            offer((r < 75) ? OP_START : OP_PAUSE, any_key());
         end else if (door_ajar) begin
            offer((r < 30) ? OP_DOOR_CLOSE : OP_TICK, any_key());
         end else if (r < 85) begin
            offer(OP_TICK, any_key());
         end else if (r < 90) begin
            offer(OP_PAUSE, any_key());
         end else if (r < 94) begin
            offer(OP_DOOR_OPEN, any_key());
         end else if (r < 98) begin
            offer(OP_KEY, any_key());
         end else begin
            offer((r % 2 == 0) ? OP_SPARE_LO : OP_SPARE_HI, any_key());
         end
         steps++;
      end
      leave_to_idle();
   endtask

   // Random opcodes and keys, unknown opcodes included
   task automatic noise_burst();
      repeat ($urandom_range(1, 6)) offer(OPCODE_W'($urandom_range(0, 7)), any_key());
   endtask

   // Register write transaction
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] value);
      csr_if.valid    = 1'b1;
      csr_if.wr_index = idx;
      csr_if.wr_data  = value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         CSR_POPCORN: popcorn_time = int'(value);
         CSR_BEEF:    beef_rate    = int'(value[PER_W-1:0]);
         CSR_CHICKEN: chicken_rate = int'(value[PER_W-1:0]);
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic drain();
      while (expected_readouts.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      readout_type       pinned_readout;
      int                goal;
      logic [SECS_W-1:0] popcorn_v;
      logic [PER_W-1:0]  beef_v;
      logic [PER_W-1:0]  chicken_v;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.opcode   = OP_TICK;
      req_if.key_code = '0;
      csr_if.valid    = 1'b0;
      csr_if.wr_index = CSR_POPCORN;
      csr_if.wr_data  = '0;
      events_sent     = 0;
      changed_events  = 0;
      results_checked = 0;
      cooks_finished  = 0;
      csr_writes      = 0;
      faults          = 0;
      tx_calm_left    = 0;
      rx_calm_left    = 0;
      rx_hold_pending = 1'b0;
      init_timer();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, register reset values
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         pinned_readout = make_readout(directed_rows[i].mode, int'(directed_rows[i].secs),
                                       directed_rows[i].blank, directed_rows[i].done);
         send_event(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pinned,
                    pinned_readout);
      end

      // random sessions under several register settings
      goal = events_sent;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: begin
               popcorn_v = POPCORN_RESET;
               beef_v    = BEEF_RESET;
               chicken_v = CHICKEN_RESET;
            end
            1: begin
               popcorn_v = '0;
               beef_v    = '0;
               chicken_v = '0;
            end
            2: begin
               popcorn_v = MAX_SECONDS;
               beef_v    = MAX_PER_UNIT;
               chicken_v = MAX_PER_UNIT;
            end
            3: begin
               popcorn_v = '1;
               beef_v    = '1;
               chicken_v = '1;
            end
            4: begin
               popcorn_v = SECS_W'($urandom_range(1, 90));
               beef_v    = PER_W'($urandom_range(0, 1023));
               chicken_v = PER_W'($urandom_range(0, 1023));
            end
            default: begin
               popcorn_v = SECS_W'(1);
               beef_v    = PER_W'(1);
               chicken_v = PER_W'(2);
            end
         endcase
         write_register(CSR_POPCORN, popcorn_v);
         write_register(CSR_BEEF, CSR_DAT_W'(beef_v));
         write_register(CSR_CHICKEN, CSR_DAT_W'(chicken_v));
         // back-pressure: result side holds off while events keep coming
         if (p == 1 || p == 4) rx_hold_pending = 1'b1;
         goal += RANDOM_ITEMS / PHASES;
         while (events_sent < goal) begin
            if ($urandom_range(0, 9) < 7) cook_session();
            else noise_burst();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      faults += expected_readouts.size();
      $display("Run covered %0d events (%0d altering the timer), %0d results checked,",
               events_sent, changed_events, results_checked);
      $display("%0d completed cooks and %0d register writes over %0d settings.",
               cooks_finished, csr_writes, PHASES);
      if (faults == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // Result receiver and checker
   // ---------------------------------------------------------------
   initial begin : result_checker
      readout_type got;
      readout_type want;
      int          stall;
      logic        bad;
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (rx_hold_pending) begin
            stall           = RX_HOLD_CYCLES;
            rx_hold_pending = 1'b0;
         end else if (rx_calm_left > 0) begin
            stall = 0;
            rx_calm_left--;
         end else begin
            stall = $urandom_range(0, 7);
            if ($urandom_range(0, 19) == 0) rx_calm_left = $urandom_range(10, 40);
         end
         if (stall != 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got.mode      = rsp_if.mode;
         got.secs      = rsp_if.remaining_seconds;
         got.min_tens  = rsp_if.minute_tens;
         got.min_units = rsp_if.minute_units;
         got.sec_tens  = rsp_if.second_tens;
         got.sec_units = rsp_if.second_units;
         got.blank     = rsp_if.display_blank;
         got.done      = rsp_if.cooking_done;
         if (got.done === 1'b1) cooks_finished++;
         if (expected_readouts.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("Error: result transaction with none expected, mode %0d secs %0d",
                        got.mode, got.secs);
         end else begin
            want = expected_readouts.pop_front();
            results_checked++;
            bad = (got.mode !== want.mode) || (got.secs !== want.secs)
               || (got.min_tens !== want.min_tens) || (got.min_units !== want.min_units)
               || (got.sec_tens !== want.sec_tens) || (got.sec_units !== want.sec_units)
               || (got.blank !== want.blank) || (got.done !== want.done);
            if (bad) begin
               faults++;
               if (faults <= REPORT_LIMIT) begin
                  $display("Error: result %0d expected mode %0d secs %0d %0d%0d:%0d%0d b%0d d%0d",
                           results_checked, want.mode, want.secs, want.min_tens,
                           want.min_units, want.sec_tens, want.sec_units, want.blank, want.done);
                  $display("       got                mode %0d secs %0d %0d%0d:%0d%0d b%0d d%0d",
                           got.mode, got.secs, got.min_tens, got.min_units, got.sec_tens,
                           got.sec_units, got.blank, got.done);
               end
            end
         end
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: ends the run when no transaction moves for too long
   // ---------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_readouts.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
